// ----- rtl/date_day_count_converter_top_defines.svh -----
// ---------------------------------------------------------------------------
// date day count converter assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef DATE_DAY_COUNT_CONVERTER_TOP_DEFINES_SVH
`define DATE_DAY_COUNT_CONVERTER_TOP_DEFINES_SVH

// property that holds at every edge
`define DDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define DDC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ddc_pkg.sv -----
// ---------------------------------------------------------------------------
// ddc_pkg
// shared types, calendar constants and table functions
// ---------------------------------------------------------------------------
`default_nettype none

package ddc_pkg;

  localparam logic [11:0] FIRST_YEAR      = 12'd1980;
  localparam logic [11:0] LAST_YEAR       = 12'd2099;
  localparam logic [6:0]  LAST_YEAR_OFS   = 7'd119;
  localparam logic [15:0] MAX_COUNT       = 16'd43830;
  localparam logic [15:0] DAYS_YEAR       = 16'd365;
  localparam logic [15:0] DAYS_LEAP_YEAR  = 16'd366;
  localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
  localparam logic [2:0]  EPOCH_WEEKDAY   = 3'd2;
  localparam logic [1:0]  LEAP_MASK       = 2'b11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH,
    ST_OUTPUT
  } ddc_state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic year_step;
    logic month_step;
    logic finish;
    logic push;
  } ddc_cmd_t;

  typedef struct packed {
    logic dec_go;
    logic year_more;
    logic month_more;
    logic out_free;
  } ddc_sts_t;

  // days before the first of month idx+1
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      4'd12:   d = 9'd365;
      default: d = 9'd0;
    endcase
    if (leap && (idx >= 4'd2) && (idx <= 4'd12)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

  // month length, zero for codes that are no month
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] l;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    l = 5'd30;
      4'd2:                                       l = leap ? 5'd29 : 5'd28;
      default:                                    l = 5'd0;
    endcase
    return l;
  endfunction

  // x mod 7 for a 6-bit value, using 8 = 1 mod 7
  function automatic logic [2:0] mod7(input logic [5:0] x);
    logic [3:0] s;
    s = {1'b0, x[5:3]} + {1'b0, x[2:0]};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ddc_ctrl.sv -----
// ---------------------------------------------------------------------------
// ddc_ctrl
// sequencer: accept, evaluate, year walk, month walk, finish, output
// ---------------------------------------------------------------------------
`default_nettype none
`include "date_day_count_converter_top_defines.svh"

module ddc_ctrl
  import ddc_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  input  wire      s_tvalid,
  output logic     s_tready,
  input  ddc_sts_t sts,
  output ddc_cmd_t cmd
);

  ddc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = sts.dec_go ? ST_YEAR : ST_OUTPUT;
      end
      ST_YEAR: begin
        if (!sts.year_more) state_next = ST_MONTH;
      end
      ST_MONTH: begin
        if (!sts.month_more) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_YEAR: begin
        cmd.year_step = sts.year_more;
      end
      ST_MONTH: begin
        cmd.month_step = sts.month_more;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      ST_OUTPUT: begin
        cmd.push = sts.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  `DDC_ASSERT(a_cmd_onehot0, $onehot0(cmd), "more than one datapath command at once")
  `DDC_ASSERT_NEXT(a_accept_to_eval, s_tvalid && s_tready, state == ST_EVAL,
                   "accepted transfer not followed by evaluation")
  `DDC_ASSERT_NEXT(a_output_holds, (state == ST_OUTPUT) && !sts.out_free,
                   state == ST_OUTPUT, "result left before output register was free")

endmodule

`default_nettype wire

// ----- rtl/ddc_dp.sv -----
// ---------------------------------------------------------------------------
// ddc_dp
// input latch, encode arithmetic, year/month walk registers, output register
// ---------------------------------------------------------------------------
`default_nettype none
`include "date_day_count_converter_top_defines.svh"

module ddc_dp
  import ddc_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  ddc_cmd_t    cmd,
  output ddc_sts_t    sts,
  input  wire  [47:0] s_tdata,
  input  wire  [0:0]  s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,
  output logic [0:0]  m_tuser
);

  logic        in_op;
  logic [11:0] in_year;
  logic [7:0]  in_month;
  logic [7:0]  in_day;
  logic [15:0] in_count;

  logic [15:0] rem_days;
  logic [6:0]  yoff;
  logic [3:0]  mon;
  logic [2:0]  wday;

  logic        res_status;
  logic [15:0] res_count;
  logic [11:0] res_year;
  logic [3:0]  res_month;
  logic [4:0]  res_day;
  logic [2:0]  res_wday;

  // walk
  logic        year_leap;
  logic [15:0] year_len;
  logic [4:0]  cur_mlen;
  logic [15:0] fin_day_full;
  logic [4:0]  fin_day;
  logic [2:0]  fin_wday;
  logic [2:0]  year_wday_next;
  logic [2:0]  month_wday_next;

  // encode
  logic [11:0] enc_ys_full;
  logic [6:0]  enc_ys;
  logic        enc_leap;
  logic [3:0]  enc_mon;
  logic [4:0]  enc_len;
  logic        enc_valid;
  logic [15:0] enc_mult;
  logic [7:0]  enc_ld_sum;
  logic [15:0] enc_count;
  logic        dec_ok;

  assign year_leap = (yoff[1:0] & LEAP_MASK) == 2'b00;
  assign year_len  = year_leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
  assign cur_mlen  = month_len(mon, year_leap);

  assign fin_day_full    = rem_days - {7'd0, cum_days(year_leap, mon - 4'd1)};
  assign fin_day         = fin_day_full[4:0];
  assign fin_wday        = mod7({3'd0, wday} + {1'b0, fin_day} - 6'd1);
  assign year_wday_next  = mod7({3'd0, wday} + (year_leap ? 6'd2 : 6'd1));
  assign month_wday_next = mod7({3'd0, wday} + {1'b0, cur_mlen});

  assign enc_ys_full = in_year - FIRST_YEAR;
  assign enc_ys      = enc_ys_full[6:0];
  assign enc_leap    = (in_year[1:0] & LEAP_MASK) == 2'b00;
  assign enc_mon     = in_month[3:0];
  assign enc_len     = month_len(enc_mon, enc_leap);
  assign enc_valid   = (in_year >= FIRST_YEAR) && (in_year <= LAST_YEAR) &&
                       (in_month >= 8'd1) && (in_month <= {4'd0, MONTHS_PER_YEAR}) &&
                       (in_day != 8'd0) && (in_day <= {3'd0, enc_len});
  assign enc_mult    = {9'd0, enc_ys} * DAYS_YEAR;
  // leap days passed before the year: (ys + 3) / 4
  assign enc_ld_sum  = {1'b0, enc_ys} + 8'd3;
  assign enc_count   = {8'd0, in_day} + {7'd0, cum_days(enc_leap, enc_mon - 4'd1)} +
                       enc_mult + {10'd0, enc_ld_sum[7:2]};

  assign dec_ok = in_op && (in_count != 16'd0) && (in_count <= MAX_COUNT);

  always_comb begin
    sts.dec_go     = dec_ok;
    sts.year_more  = rem_days > year_len;
    sts.month_more = (mon < MONTHS_PER_YEAR) &&
                     ({7'd0, cum_days(year_leap, mon)} < rem_days);
    sts.out_free   = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_op    <= s_tuser[0];
      in_year  <= s_tdata[11:0];
      in_month <= s_tdata[19:12];
      in_day   <= s_tdata[27:20];
      in_count <= s_tdata[43:28];
    end
    if (cmd.eval) begin
      res_status <= in_op ? !dec_ok : !enc_valid;
      res_count  <= (!in_op && enc_valid) ? enc_count : 16'd0;
      res_year   <= 12'd0;
      res_month  <= 4'd0;
      res_day    <= 5'd0;
      res_wday   <= 3'd0;
      rem_days   <= in_count;
      yoff       <= 7'd0;
      mon        <= 4'd1;
      wday       <= EPOCH_WEEKDAY;
    end
    if (cmd.year_step) begin
      rem_days <= rem_days - year_len;
      yoff     <= yoff + 7'd1;
      wday     <= year_wday_next;
    end
    if (cmd.month_step) begin
      mon  <= mon + 4'd1;
      wday <= month_wday_next;
    end
    if (cmd.finish) begin
      res_year  <= FIRST_YEAR + {5'd0, yoff};
      res_month <= mon;
      res_day   <= fin_day;
      res_wday  <= fin_wday;
    end
    if (cmd.push) begin
      m_tdata <= {res_wday, res_day, res_month, res_year, res_count};
      m_tuser <= res_status;
    end
  end

  `DDC_ASSERT_IMPL(a_year_in_span, cmd.year_step, yoff < LAST_YEAR_OFS,
                   "year walk passed the last year")
  `DDC_ASSERT_IMPL(a_finish_day_ok, cmd.finish,
                   (mon >= 4'd1) && (mon <= MONTHS_PER_YEAR) && (fin_day != 5'd0) &&
                   (fin_day <= cur_mlen), "decoded day outside its month")
  `DDC_ASSERT_IMPL(a_error_clears, cmd.push && res_status,
                   (res_count == 16'd0) && (res_year == 12'd0) && (res_month == 4'd0) &&
                   (res_day == 5'd0) && (res_wday == 3'd0),
                   "error result carries nonzero fields")

endmodule

`default_nettype wire

// ----- rtl/date_day_count_converter_top.sv -----
// ---------------------------------------------------------------------------
// date_day_count_converter_top
// calendar date <-> day count converter, 1980-01-01 is day 1
// ---------------------------------------------------------------------------
// Each transfer on the slave side gives one result transfer on the master
// side. Encode (operation 0) checks year 1980..2099, month 1..12 and the day
// against the month length and returns the day count. Decode (operation 1)
// walks one year per cycle, then one month per cycle, and then sets the
// day of the month and the weekday. An invalid date or a count of 0 or
// past 43830 gives status 1 with all data zero. The result sits in an
// output register, so a new item is accepted while the previous result
// still waits on m_tready.
// ---------------------------------------------------------------------------
`default_nettype none

module date_day_count_converter_top
  import ddc_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  // slave side
  input  wire         s_tvalid,
  output logic        s_tready,
  // year[11:0], month[19:12], day_of_month[27:20], day_count[43:28], zero[47:44]
  input  wire  [47:0] s_tdata,
  // operation[0]
  input  wire  [0:0]  s_tuser,
  // master side
  output logic        m_tvalid,
  input  wire         m_tready,
  // day_count_out[15:0], year_out[27:16], month_out[31:28], day_out[36:32],
  // weekday_out[39:37]
  output logic [39:0] m_tdata,
  // status[0]
  output logic [0:0]  m_tuser
);

  // command and status between sequencer and datapath
  ddc_cmd_t cmd;
  ddc_sts_t sts;

  // sequencer: owns s_tready and the order of the walk steps
  ddc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: input latch, arithmetic and the master-side output register
  ddc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
